### rtl/core/pct_pkg.sv
package pct_pkg;

    localparam int PEER_W   = 64;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int LEN_W    = 25;
    localparam int BYTES_W  = 40;
    localparam int LANE_W   = 8;
    localparam int LANE_IW  = 3;
    localparam int NUM_LANES = PEER_W / LANE_W;

    localparam logic [1:0] ACT_CLAIM    = 2'd0;
    localparam logic [1:0] ACT_COMPLETE = 2'd1;
    localparam logic [1:0] ACT_ABORT    = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NONE      = 2'd1;
    localparam logic [1:0] STAT_HASH_FAIL = 2'd2;
    localparam logic [1:0] STAT_RANGE     = 2'd3;

    localparam logic [1:0] CFG_PIECE_COUNT    = 2'd0;
    localparam logic [1:0] CFG_NOMINAL_LENGTH = 2'd1;
    localparam logic [1:0] CFG_TOTAL_BYTES    = 2'd2;

    localparam logic [COUNT_W-1:0] RST_PIECE_COUNT    = 7'd64;
    localparam logic [LEN_W-1:0]   RST_NOMINAL_LENGTH = 25'd262144;
    localparam logic [BYTES_W-1:0] RST_TOTAL_BYTES    = 40'd16777216;

    typedef struct packed {
        logic [1:0]        action;
        logic [PEER_W-1:0] peer_mask;
        logic [IDX_W-1:0]  piece_sel;
        logic              hash_ok;
    } pct_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   granted_index;
        logic               held_at_index;
        logic [LEN_W-1:0]   length_at_index;
        logic [BYTES_W-1:0] bytes_done;
        logic               all_done;
    } pct_out_t;

    typedef struct packed {
        logic               hit;
        logic [LANE_IW-1:0] pos;
    } lane_res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } pct_state_t;

endpackage

### rtl/core/pct_lane.sv
module pct_lane (
    input  logic [pct_pkg::LANE_W-1:0] cand,
    output pct_pkg::lane_res_t         res
);
    import pct_pkg::*;

    // lowest set bit of this slice
    always_comb begin
        res.hit = 1'b0;
        res.pos = '0;
        for (int i = LANE_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
                res.hit = 1'b1;
                res.pos = LANE_IW'(i);
            end
        end
    end

endmodule

### rtl/core/pct_merge.sv
module pct_merge (
    input  pct_pkg::lane_res_t           lanes [pct_pkg::NUM_LANES],
    output logic                         found,
    output logic [pct_pkg::IDX_W-1:0]    index
);
    import pct_pkg::*;

    always_comb begin
        found = 1'b0;
        index = '0;
        for (int l = NUM_LANES - 1; l >= 0; l--) begin
            if (lanes[l].hit) begin
                found = 1'b1;
                index = {(IDX_W - LANE_IW)'(l), lanes[l].pos};
            end
        end
    end

endmodule

### rtl/core/piece_claim_tracker_unit.sv
// channel  | ports                               | direction
// input    | s_valid s_ready s_data              | in
// result   | m_valid m_ready m_data              | out
// config   | cfg_valid cfg_ready cfg_index/data  | in
//
// One transaction at a time: accept, lane scan, commit; the lane results
// are registered ahead of the merge and state update.
// A result waiting in the output register holds the commit step only.
// Synchronous active-low reset clears both bitmaps, the count and byte total
// and loads the register defaults. After a register write, last-piece length
// passes prod_reg, then last_len_reg; no input is taken in a write cycle.
module piece_claim_tracker_unit #(
    parameter int MAX_PIECES = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  pct_pkg::pct_in_t        s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output pct_pkg::pct_out_t       m_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [39:0]             cfg_data
);
    import pct_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_PIECES);

    pct_state_t state_reg, state_next;

    logic [COUNT_W-1:0]    piece_count_reg;
    logic [LEN_W-1:0]      nominal_reg;
    logic [BYTES_W-1:0]    total_reg;
    logic [31:0]           prod_reg;
    logic [LEN_W-1:0]      last_len_reg;

    logic [MAX_PIECES-1:0] held_reg, held_next;
    logic [MAX_PIECES-1:0] claimed_reg, claimed_next;
    logic [COUNT_W-1:0]    held_cnt_reg, held_cnt_next;
    logic [BYTES_W-1:0]    bytes_reg, bytes_next;

    pct_in_t   item_reg;
    pct_out_t  out_reg, out_next;
    logic      out_valid_reg;
    lane_res_t lane_reg [NUM_LANES];
    lane_res_t lane_res [NUM_LANES];

    logic                  cfg_we;
    logic [COUNT_W-1:0]    n;
    logic [PEER_W-1:0]     range_mask, held64, claimed64, cand, bit64;
    logic [PEER_W-1:0]     held_next64;
    logic                  found;
    logic [IDX_W-1:0]      grant_idx;
    logic                  in_range, was_held, commit;
    logic [LEN_W-1:0]      len_idx;
    logic [BYTES_W:0]      sum;
    logic [BYTES_W:0]      diff;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    assign n = (piece_count_reg > MAX_N) ? MAX_N : piece_count_reg;

    always_comb begin
        for (int i = 0; i < PEER_W; i++) begin
            range_mask[i] = (COUNT_W'(i) < n);
        end
    end

    assign held64    = PEER_W'(held_reg);
    assign claimed64 = PEER_W'(claimed_reg);
    assign cand      = item_reg.peer_mask & ~held64 & ~claimed64 & range_mask;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        pct_lane u_lane (
            .cand (cand[l*LANE_W +: LANE_W]),
            .res  (lane_res[l])
        );
    end

    pct_merge u_merge (
        .lanes (lane_reg),
        .found (found),
        .index (grant_idx)
    );

    // config registers and last-piece length
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piece_count_reg <= RST_PIECE_COUNT;
            nominal_reg     <= RST_NOMINAL_LENGTH;
            total_reg       <= RST_TOTAL_BYTES;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PIECE_COUNT:    piece_count_reg <= cfg_data[COUNT_W-1:0];
                CFG_NOMINAL_LENGTH: nominal_reg     <= cfg_data[LEN_W-1:0];
                CFG_TOTAL_BYTES:    total_reg       <= cfg_data[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    assign diff = {1'b0, total_reg} - (BYTES_W + 1)'(prod_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= 32'(nominal_reg) * 32'((n == '0) ? '0 : n - 1'b1);
        if (diff[BYTES_W]) begin
            last_len_reg <= '0;
        end else if (diff[BYTES_W-1:LEN_W] != '0) begin
            last_len_reg <= '1;
        end else begin
            last_len_reg <= diff[LEN_W-1:0];
        end
    end

    // commit logic
    assign bit64    = PEER_W'(1) << item_reg.piece_sel;
    assign in_range = (COUNT_W'(item_reg.piece_sel) < n);
    assign was_held = held64[item_reg.piece_sel];
    assign len_idx  = ((COUNT_W'(item_reg.piece_sel) + 1'b1) < n) ? nominal_reg
                                                                   : last_len_reg;
    assign sum      = {1'b0, bytes_reg} + (BYTES_W + 1)'(len_idx);
    assign commit   = (state_reg == ST_COMMIT) && (!out_valid_reg || m_ready);

    always_comb begin
        held_next     = held_reg;
        claimed_next  = claimed_reg;
        held_cnt_next = held_cnt_reg;
        bytes_next    = bytes_reg;
        out_next      = '0;
        out_next.status = STAT_OK;
        case (item_reg.action)
            ACT_CLAIM: begin
                if (found) begin
                    out_next.granted_index = grant_idx;
                    claimed_next = claimed_reg
                                 | MAX_PIECES'(PEER_W'(1) << grant_idx);
                end else begin
                    out_next.status = STAT_NONE;
                end
            end
            ACT_COMPLETE: begin
                if (!in_range) begin
                    out_next.status = STAT_RANGE;
                end else if (!item_reg.hash_ok) begin
                    claimed_next    = claimed_reg & ~MAX_PIECES'(bit64);
                    out_next.status = STAT_HASH_FAIL;
                end else if (!was_held) begin
                    held_next     = held_reg | MAX_PIECES'(bit64);
                    bytes_next    = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
                    held_cnt_next = held_cnt_reg + 1'b1;
                end
            end
            ACT_ABORT: begin
                if (!in_range) begin
                    out_next.status = STAT_RANGE;
                end else if (!was_held) begin
                    claimed_next = claimed_reg & ~MAX_PIECES'(bit64);
                end
            end
            default: ;
        endcase
        held_next64              = PEER_W'(held_next);
        out_next.held_at_index   = in_range && held_next64[item_reg.piece_sel];
        out_next.length_at_index = in_range ? len_idx : '0;
        out_next.bytes_done      = bytes_next;
        out_next.all_done        = (held_cnt_next == n);
    end

    // control FSM
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !cfg_valid;
                if (s_valid && !cfg_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg      <= '0;
            claimed_reg   <= '0;
            held_cnt_reg  <= '0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (commit) begin
                held_reg     <= held_next;
                claimed_reg  <= claimed_next;
                held_cnt_reg <= held_cnt_next;
                bytes_reg    <= bytes_next;
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == ST_SCAN) begin
            lane_reg <= lane_res;
        end
        if (commit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### rtl/core/pct_checker.sv
module pct_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input pct_pkg::pct_out_t    m_data
);
    import pct_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    a_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STAT_RANGE
        |-> !m_data.held_at_index && m_data.length_at_index == '0)
        else $error("out-of-range result carries per-index data");

    a_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |-> m_data.granted_index == '0)
        else $error("grant index set without a grant");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind piece_claim_tracker_unit pct_checker u_pct_checker (.*);
